// ===== design/assert_macros.svh =====
// Assertion macros shared by the aggregation table RTL.
// Included by the modules that carry concurrent checks; no other dependency.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("check failed: %m");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
		else $error("forbidden condition: %m");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== design/giat_pkg.sv =====
// Types and constants of the group aggregation table.
// Used by the controller, the datapath and the top level.
`default_nettype none

package giat_pkg;

	localparam logic signed [63:0] MOST_POS_64 = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] MOST_NEG_64 = 64'sh8000_0000_0000_0000;

	localparam logic REPLY_READ = 1'b0;
	localparam logic REPLY_DONE = 1'b1;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_MUL_LOW,
		ST_MUL_CROSS,
		ST_SQUARE,
		ST_WRITE,
		ST_REPLY
	} state_t;

	// One table entry, stored as a single RAM word.
	typedef struct packed {
		logic [63:0]        sum;
		logic [63:0]        squares;
		logic [63:0]        count;
		logic signed [63:0] min_v;
		logic signed [63:0] max_v;
	} entry_t;

	localparam entry_t ENTRY_INIT = '{
		sum:     64'd0,
		squares: 64'd0,
		count:   64'd0,
		min_v:   MOST_POS_64,
		max_v:   MOST_NEG_64
	};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic init_wr;
		logic accept;
		logic clear_wr;
		logic rd_en;
		logic mul_low;
		logic mul_cross;
		logic sq_en;
		logic upd_wr;
		logic reply_ld;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd_in;
		logic last_q;
		logic init_last;
		logic slot_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== design/giat_if.sv =====
// Channel interfaces of the aggregation table: request and reply words.
// Stand-alone; valid/ready handshake with the payload fields of each word.
`default_nettype none

interface giat_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [9:0]         group_id;
	logic signed [63:0] value;
	logic               row_valid;
	logic               last_row;

	modport source (output valid, output cmd, output group_id, output value,
		output row_valid, output last_row, input ready);
	modport sink (input valid, input cmd, input group_id, input value,
		input row_valid, input last_row, output ready);
endinterface

interface giat_rsp_if;
	logic               valid;
	logic               ready;
	logic               reply_kind;
	logic [9:0]         reply_group;
	logic signed [63:0] total_sum;
	logic signed [63:0] total_squares;
	logic [62:0]        row_count;
	logic signed [63:0] smallest;
	logic signed [63:0] largest;
	logic               empty_res;

	modport source (output valid, output reply_kind, output reply_group,
		output total_sum, output total_squares, output row_count, output smallest,
		output largest, output empty_res, input ready);
	modport sink (input valid, input reply_kind, input reply_group,
		input total_sum, input total_squares, input row_count, input smallest,
		input largest, input empty_res, output ready);
endinterface

`default_nettype wire

// ===== design/group_int_aggregate_table_unit.sv =====
// Top level of the group-by integer aggregation table.
// Depends on giat_pkg, giat_if, giat_ram, giat_dp and giat_ctrl.
//
//   Channel  Direction  Word
//   req      in         cmd, group_id, value, row_valid, last_row
//   rsp      out        reply_kind, reply_group, totals, min, max, empty flag
//
// A clear writes its entry as it is taken; a read passes through a reply state, and an
// update through low product, cross product, square and write states (and a reply state
// for a done reply). The registered read of the entry RAM and the single 32x32 multiplier
// used twice for the square set this sequence. After reset a clearing pass writes every
// entry with req held not ready. A reply waits in an output register; the next request word
// is taken while it stalls, and only a second reply waits for it to drain.
`default_nettype none

module group_int_aggregate_table_unit #(
	parameter int GROUP_COUNT = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	giat_req_if.sink   req,
	giat_rsp_if.source rsp
);

	giat_pkg::ctl_t ctl;
	giat_pkg::sts_t sts;
	logic           req_ready;

	assign req.ready = req_ready;

	giat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	giat_dp #(
		.GROUP_COUNT(GROUP_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.req_cmd       (req.cmd),
		.req_group_id  (req.group_id),
		.req_value     (req.value),
		.req_row_valid (req.row_valid),
		.req_last_row  (req.last_row),
		.rsp           (rsp)
	);

endmodule

`default_nettype wire

// ===== design/giat_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module giat_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== design/giat_dp.sv =====
// Datapath of the aggregation table: entry RAM, shared 32x32 multiplier,
// entry update logic and the reply register. Depends on giat_pkg, giat_ram.
`default_nettype none
`include "assert_macros.svh"

module giat_dp #(
	parameter int GROUP_COUNT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  giat_pkg::ctl_t     ctl,
	output giat_pkg::sts_t     sts,
	input  logic [1:0]         req_cmd,
	input  logic [9:0]         req_group_id,
	input  logic signed [63:0] req_value,
	input  logic               req_row_valid,
	input  logic               req_last_row,
	giat_rsp_if.source         rsp
);

	localparam int AW = $clog2(GROUP_COUNT);
	localparam logic [16:0] GROUP_LIMIT = 17'(GROUP_COUNT);
	localparam int EW = $bits(giat_pkg::entry_t);

	logic [AW-1:0]       clr_cnt_q;
	giat_pkg::cmd_t      cmd_q;
	logic [9:0]          gid_q;
	logic [AW-1:0]       addr_q;
	logic signed [63:0]  val_q;
	logic                row_valid_q;
	logic                last_q;
	logic                in_range_q;
	logic [63:0]         prod_low_q;
	logic [30:0]         cross_q;
	logic [63:0]         square_q;
	logic                out_valid_q;

	logic [16:0]         gid_ext;
	logic [AW-1:0]       addr_in;
	logic                in_range_in;
	logic [31:0]         mul_b;
	logic [63:0]         mul_p;
	giat_pkg::entry_t    ent_rd;
	giat_pkg::entry_t    ent_new;
	logic [EW-1:0]       rd_word;
	logic                ram_wr_en;
	logic [AW-1:0]       ram_wr_addr;
	giat_pkg::entry_t    ram_wr_ent;
	logic                rd_empty;

	assign gid_ext     = 17'(req_group_id);
	assign addr_in     = gid_ext[AW-1:0];
	assign in_range_in = gid_ext < GROUP_LIMIT;

	always_comb begin
		sts.cmd_in    = giat_pkg::cmd_t'(req_cmd);
		sts.last_q    = last_q;
		sts.init_last = clr_cnt_q == AW'(GROUP_COUNT - 1);
		sts.slot_free = !out_valid_q || rsp.ready;
	end

	// Clearing pass address, walked once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (ctl.init_wr) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q       <= giat_pkg::cmd_t'(req_cmd);
			gid_q       <= req_group_id;
			addr_q      <= addr_in;
			val_q       <= req_value;
			row_valid_q <= req_row_valid;
			last_q      <= req_last_row;
			in_range_q  <= in_range_in;
		end
	end

	// The low 64 bits of value*value are lo*lo plus twice lo*hi shifted by 32,
	// so one 32x32 multiplier, used in the low and then the cross step, covers the square.
	assign mul_b = ctl.mul_cross ? val_q[63:32] : val_q[31:0];
	assign mul_p = {32'd0, val_q[31:0]} * {32'd0, mul_b};

	always_ff @(posedge clk) begin
		if (ctl.mul_low) begin
			prod_low_q <= mul_p;
		end
		if (ctl.mul_cross) begin
			cross_q <= mul_p[30:0];
		end
		if (ctl.sq_en) begin
			square_q <= prod_low_q + {cross_q, 33'd0};
		end
	end

	assign ent_rd = giat_pkg::entry_t'(rd_word);

	always_comb begin
		ent_new.sum     = ent_rd.sum + val_q;
		ent_new.squares = ent_rd.squares + square_q;
		ent_new.count   = ent_rd.count + 64'd1;
		ent_new.min_v   = (val_q < ent_rd.min_v) ? val_q : ent_rd.min_v;
		ent_new.max_v   = (ent_rd.max_v < val_q) ? val_q : ent_rd.max_v;
	end

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = addr_q;
		ram_wr_ent  = giat_pkg::ENTRY_INIT;
		if (ctl.init_wr) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = clr_cnt_q;
		end else if (ctl.clear_wr) begin
			ram_wr_en   = in_range_in;
			ram_wr_addr = addr_in;
		end else if (ctl.upd_wr) begin
			ram_wr_en  = row_valid_q && in_range_q;
			ram_wr_ent = ent_new;
		end
	end

	giat_ram #(
		.WIDTH(EW),
		.DEPTH(GROUP_COUNT)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (EW'(ram_wr_ent)),
		.rd_en   (ctl.rd_en),
		.rd_addr (addr_in),
		.rd_data (rd_word)
	);

	assign rd_empty = !in_range_q || (ent_rd.count == 64'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.reply_ld) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.reply_ld) begin
			rsp.reply_group <= gid_q;
			if (cmd_q == giat_pkg::CMD_READ) begin
				rsp.reply_kind    <= giat_pkg::REPLY_READ;
				rsp.total_sum     <= in_range_q ? ent_rd.sum : 64'd0;
				rsp.total_squares <= in_range_q ? ent_rd.squares : 64'd0;
				rsp.row_count     <= in_range_q ? ent_rd.count[62:0] : 63'd0;
				rsp.smallest      <= rd_empty ? giat_pkg::MOST_POS_64 : ent_rd.min_v;
				rsp.largest       <= rd_empty ? giat_pkg::MOST_NEG_64 : ent_rd.max_v;
				rsp.empty_res     <= rd_empty;
			end else begin
				rsp.reply_kind    <= giat_pkg::REPLY_DONE;
				rsp.total_sum     <= '0;
				rsp.total_squares <= '0;
				rsp.row_count     <= '0;
				rsp.smallest      <= '0;
				rsp.largest       <= '0;
				rsp.empty_res     <= 1'b0;
			end
		end
	end

	assign rsp.valid = out_valid_q;

	`ASSERT_CLK(a_reply_shows, clk, arst_n, ctl.reply_ld |=> out_valid_q)
	`ASSERT_NEVER(a_no_rw_overlap, clk, arst_n, ram_wr_en && ctl.rd_en)
	`ASSERT_CLK(a_clear_wraps, clk, arst_n, (ctl.init_wr && sts.init_last) |=> clr_cnt_q == AW'(GROUP_COUNT))

endmodule

`default_nettype wire

// ===== design/giat_ctrl.sv =====
// Controller of the aggregation table: sequences the clearing pass, the
// read-modify-write of an update and the reply load. Depends on giat_pkg.
`default_nettype none
`include "assert_macros.svh"

module giat_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  giat_pkg::sts_t sts,
	output giat_pkg::ctl_t ctl
);

	giat_pkg::state_t state_q;
	giat_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= giat_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			giat_pkg::ST_INIT: begin
				ctl.init_wr = 1'b1;
				if (sts.init_last) begin
					state_d = giat_pkg::ST_IDLE;
				end
			end
			giat_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.accept = 1'b1;
					unique case (sts.cmd_in)
						giat_pkg::CMD_CLEAR: begin
							ctl.clear_wr = 1'b1;
						end
						giat_pkg::CMD_UPDATE: begin
							ctl.rd_en = 1'b1;
							state_d   = giat_pkg::ST_MUL_LOW;
						end
						giat_pkg::CMD_READ: begin
							ctl.rd_en = 1'b1;
							state_d   = giat_pkg::ST_REPLY;
						end
						default: begin
						end
					endcase
				end
			end
			giat_pkg::ST_MUL_LOW: begin
				ctl.mul_low = 1'b1;
				state_d     = giat_pkg::ST_MUL_CROSS;
			end
			giat_pkg::ST_MUL_CROSS: begin
				ctl.mul_cross = 1'b1;
				state_d       = giat_pkg::ST_SQUARE;
			end
			giat_pkg::ST_SQUARE: begin
				ctl.sq_en = 1'b1;
				state_d   = giat_pkg::ST_WRITE;
			end
			giat_pkg::ST_WRITE: begin
				ctl.upd_wr = 1'b1;
				state_d    = sts.last_q ? giat_pkg::ST_REPLY : giat_pkg::ST_IDLE;
			end
			giat_pkg::ST_REPLY: begin
				if (sts.slot_free) begin
					ctl.reply_ld = 1'b1;
					state_d      = giat_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = giat_pkg::ST_IDLE;
			end
		endcase
	end

	`ASSERT_CLK(a_load_needs_slot, clk, arst_n, ctl.reply_ld |-> sts.slot_free)
	`ASSERT_CLK(a_write_exits, clk, arst_n, state_q == giat_pkg::ST_WRITE |=> (state_q == giat_pkg::ST_REPLY || state_q == giat_pkg::ST_IDLE))
	`ASSERT_NEVER(a_no_accept_in_init, clk, arst_n, ctl.init_wr && ctl.accept)

endmodule

`default_nettype wire
